FILE: design/md5_hash_engine_assert.svh
// Assertion macros used by the engine top level.
`ifndef MD5_HASH_ENGINE_ASSERT_SVH
`define MD5_HASH_ENGINE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define MD5_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MD5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/md5_pkg.sv
// Package: MD5 types, initial values and round tables.
package md5_pkg;

  typedef logic [31:0] word_t;

  localparam word_t InitA = 32'h67452301;
  localparam word_t InitB = 32'hEFCDAB89;
  localparam word_t InitC = 32'h98BADCFE;
  localparam word_t InitD = 32'h10325476;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned WordAddrW  = $clog2(BlockWords);

  localparam logic [7:0] PadMarker = 8'h80;

  localparam word_t RoundConst [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [WordAddrW-1:0] msg_index(input logic [5:0] rnd);
    logic [WordAddrW-1:0] idx;
    case (rnd[5:4])
      2'd0:    idx = rnd[3:0];
      2'd1:    idx = WordAddrW'(rnd[3:0] * 4'd5 + 4'd1);
      2'd2:    idx = WordAddrW'(rnd[3:0] * 4'd3 + 4'd5);
      default: idx = WordAddrW'(rnd[3:0] * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    return RotAmount[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage

FILE: design/md5_in_if.sv
// Interface: message byte channel.
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

FILE: design/md5_out_if.sv
// Interface: digest channel.
interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word_a;
  logic [31:0] digest_word_b;
  logic [31:0] digest_word_c;
  logic [31:0] digest_word_d;

  modport source (output valid, output digest_word_a, output digest_word_b,
                  output digest_word_c, output digest_word_d, input ready);
  modport sink (input valid, input digest_word_a, input digest_word_b,
                input digest_word_c, input digest_word_d, output ready);
endinterface

FILE: design/md5_ram.sv
// Generic simple dual-port RAM with registered read.
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/md5_hash_engine.sv
// Top level: streaming MD5 engine with the message block held in a word RAM.
// A byte that does not complete a block is taken while idle; a completed block
// holds off input through one RAM read-ahead, 64 rounds on the shared round unit, one fold.
// Finishing writes up to 16 padding words, compresses one or two blocks, then emits.
// Sustained throughput is set by the round loop over the RAM port, which holds off input.
// Reset clears counters, length and chaining to the MD5 initial values; RAM keeps no reset.
`include "md5_hash_engine_assert.svh"

module md5_hash_engine (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_e;

  state_e                            state_q;
  logic [5:0]                        cnt_q;
  logic [63:0]                       bits_q;
  md5_pkg::word_t                    acc_q;
  md5_pkg::word_t                    h_q [4];
  md5_pkg::word_t                    va_q, vb_q, vc_q, vd_q;
  logic [5:0]                        rnd_q;
  logic [md5_pkg::WordAddrW-1:0]     wi_q;
  logic                              fin_q;
  logic                              mark_q;
  logic                              two_q;
  md5_pkg::word_t                    dig_q [4];
  logic                              out_vld_q;

  logic                              in_xfer;
  logic                              out_xfer;
  logic [1:0]                        lane;
  logic [5:0]                        cnt_inc;
  md5_pkg::word_t                    acc_new;
  md5_pkg::word_t                    mark_word;
  md5_pkg::word_t                    pad_word;
  logic                              ram_we;
  logic [md5_pkg::WordAddrW-1:0]     ram_waddr;
  md5_pkg::word_t                    ram_wdata;
  logic [md5_pkg::WordAddrW-1:0]     ram_raddr;
  md5_pkg::word_t                    ram_rdata;
  md5_pkg::word_t                    f_val;
  md5_pkg::word_t                    t_val;
  logic [63:0]                       rot_val;
  md5_pkg::word_t                    b_new;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_xfer   = out_o.valid && out_o.ready;

  assign out_o.valid         = out_vld_q;
  assign out_o.digest_word_a = dig_q[0];
  assign out_o.digest_word_b = dig_q[1];
  assign out_o.digest_word_c = dig_q[2];
  assign out_o.digest_word_d = dig_q[3];

  assign lane    = cnt_q[1:0];
  assign cnt_inc = in_i.has_byte ? 6'(cnt_q + 6'd1) : cnt_q;

  always_comb begin
    acc_new = acc_q;
    acc_new[8*lane +: 8] = in_i.data_byte;
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < lane) begin
        mark_word[8*j +: 8] = acc_q[8*j +: 8];
      end else if (2'(j) == lane) begin
        mark_word[8*j +: 8] = md5_pkg::PadMarker;
      end else begin
        mark_word[8*j +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    if (mark_q) begin
      pad_word = mark_word;
    end else if (!two_q && (wi_q == md5_pkg::WordAddrW'(14))) begin
      pad_word = bits_q[31:0];
    end else if (!two_q && (wi_q == md5_pkg::WordAddrW'(15))) begin
      pad_word = bits_q[63:32];
    end else begin
      pad_word = '0;
    end
  end

  assign ram_we    = (state_q == ST_PAD) || (in_xfer && in_i.has_byte && (lane == 2'd3));
  assign ram_waddr = (state_q == ST_PAD) ? wi_q : cnt_q[5:2];
  assign ram_wdata = (state_q == ST_PAD) ? pad_word : acc_new;
  assign ram_raddr = md5_pkg::msg_index((state_q == ST_ROUND) ? 6'(rnd_q + 6'd1) : 6'd0);

  md5_ram #(
    .Width (32),
    .Depth (md5_pkg::BlockWords)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = (vb_q & vc_q) | (~vb_q & vd_q);
      2'd1:    f_val = (vb_q & vd_q) | (vc_q & ~vd_q);
      2'd2:    f_val = vb_q ^ vc_q ^ vd_q;
      default: f_val = vc_q ^ (vb_q | ~vd_q);
    endcase
    t_val   = va_q + f_val + ram_rdata + md5_pkg::RoundConst[rnd_q];
    rot_val = {t_val, t_val} << md5_pkg::rot_amount(rnd_q);
    b_new   = vb_q + rot_val[63:32];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      bits_q    <= '0;
      acc_q     <= '0;
      h_q[0]    <= md5_pkg::InitA;
      h_q[1]    <= md5_pkg::InitB;
      h_q[2]    <= md5_pkg::InitC;
      h_q[3]    <= md5_pkg::InitD;
      va_q      <= '0;
      vb_q      <= '0;
      vc_q      <= '0;
      vd_q      <= '0;
      rnd_q     <= '0;
      wi_q      <= '0;
      fin_q     <= 1'b0;
      mark_q    <= 1'b0;
      two_q     <= 1'b0;
      dig_q     <= '{default: '0};
      out_vld_q <= 1'b0;
    end else begin
      if (out_xfer && (state_q != ST_EMIT)) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            fin_q  <= in_i.last;
            mark_q <= 1'b1;
            wi_q   <= cnt_inc[5:2];
            two_q  <= (cnt_inc >= 6'd56);
            if (in_i.has_byte) begin
              cnt_q  <= cnt_inc;
              bits_q <= bits_q + 64'd8;
              acc_q  <= acc_new;
            end
            if (in_i.has_byte && (cnt_q == 6'd63)) begin
              state_q <= ST_LOAD;
            end else if (in_i.last) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          mark_q <= 1'b0;
          wi_q   <= md5_pkg::WordAddrW'(wi_q + 1'b1);
          if (wi_q == md5_pkg::WordAddrW'(15)) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          va_q    <= h_q[0];
          vb_q    <= h_q[1];
          vc_q    <= h_q[2];
          vd_q    <= h_q[3];
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          va_q  <= vd_q;
          vd_q  <= vc_q;
          vc_q  <= vb_q;
          vb_q  <= b_new;
          rnd_q <= 6'(rnd_q + 6'd1);
          if (rnd_q == 6'd63) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          h_q[0] <= h_q[0] + va_q;
          h_q[1] <= h_q[1] + vb_q;
          h_q[2] <= h_q[2] + vc_q;
          h_q[3] <= h_q[3] + vd_q;
          wi_q   <= '0;
          if (!fin_q) begin
            state_q <= ST_IDLE;
          end else if (mark_q || two_q) begin
            two_q   <= 1'b0;
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_vld_q || out_o.ready) begin
            dig_q     <= h_q;
            out_vld_q <= 1'b1;
            h_q[0]    <= md5_pkg::InitA;
            h_q[1]    <= md5_pkg::InitB;
            h_q[2]    <= md5_pkg::InitC;
            h_q[3]    <= md5_pkg::InitD;
            cnt_q     <= '0;
            bits_q    <= '0;
            fin_q     <= 1'b0;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `MD5_ASSERT_NOW(a_no_write_in_rounds, state_q == ST_ROUND, !ram_we,
                  "block RAM written during rounds")
  `MD5_ASSERT_NEXT(a_full_block_loads,
                   in_xfer && in_i.has_byte && (cnt_q == 6'd63),
                   state_q == ST_LOAD && cnt_q == 6'd0,
                   "full block did not start compression")
  `MD5_ASSERT_NOW(a_fold_after_last_round, state_q == ST_FOLD, rnd_q == 6'd0,
                  "fold reached without all rounds")
  `MD5_ASSERT_NOW(a_emit_restarts, $rose(out_vld_q),
                  state_q == ST_IDLE && cnt_q == 6'd0 && bits_q == 64'd0,
                  "digest emitted without message restart")

endmodule
